// File: rtl/goc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro offset calibration package
// Shared types, register indexes, reset values and default parameter values
// for the gyro offset calibration and low-pass filter block.
// ----------------------------------------------------------------------------
package goc_pkg;

    localparam int AVG_SHIFT_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int ALPHA_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_NEEDED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q16     = 2'd3;

    localparam logic [7:0]         QUIET_LIMIT_RST   = 8'd5;
    localparam logic [7:0]         QUIET_NEEDED_RST  = 8'd30;
    localparam logic [9:0]         DISCARD_COUNT_RST = 10'd100;
    localparam logic [ALPHA_W-1:0] ALPHA_Q16_RST     = 16'd9830;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_QUIET   = 2'd1,
        PH_DISCARD = 2'd2,
        PH_SUM     = 2'd3
    } cal_phase_t;

    typedef struct packed {
        logic [7:0] quiet_limit;
        logic [7:0] quiet_needed;
        logic [9:0] discard_count;
    } cal_cfg_t;

    typedef struct packed {
        cal_phase_t phase;
        logic       done;
    } cal_status_t;

endpackage

// File: rtl/gyro_offset_calibrate_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro offset calibration with first-order low-pass filter
// A result passes through the input register and then the output register;
// while the output is stalled it waits in the input register.
// Throughput: one transaction per cycle while the output is not stalled; the
// filter update of each axis is one combinational multiply-add recurrence.
// Reset: synchronous, active low; clears filter state, offsets, sums and phase
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module gyro_offset_calibrate_lowpass
    import goc_pkg::*;
#(
    parameter int AVG_SHIFT = AVG_SHIFT_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // raw_x, raw_y, raw_z
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // rate_x, rate_y, rate_z
    output logic [2:0]           m_tuser,   // cal_phase, cal_done
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic               in_valid_reg;
    logic               in_req_reg;
    sample_t            in_raw_reg [3];
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;
    logic [2:0]         out_user_reg;
    logic               advance;
    cal_cfg_t           cal_cfg_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    sample_t            offset_eff [3];
    sample_t            rate [3];
    cal_status_t        status;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_cfg_reg.quiet_limit   <= QUIET_LIMIT_RST;
            cal_cfg_reg.quiet_needed  <= QUIET_NEEDED_RST;
            cal_cfg_reg.discard_count <= DISCARD_COUNT_RST;
            alpha_reg                 <= ALPHA_Q16_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_QUIET_LIMIT:   cal_cfg_reg.quiet_limit   <= cfg_wdata[7:0];
                REG_QUIET_NEEDED:  cal_cfg_reg.quiet_needed  <= cfg_wdata[7:0];
                REG_DISCARD_COUNT: cal_cfg_reg.discard_count <= cfg_wdata[9:0];
                REG_ALPHA_Q16:     alpha_reg                 <= cfg_wdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg    <= s_tuser;
            in_raw_reg[0] <= s_tdata[15:0];
            in_raw_reg[1] <= s_tdata[31:16];
            in_raw_reg[2] <= s_tdata[47:32];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        goc_axis_filter #(
            .FRAC_BITS (FRAC_BITS)
        ) u_filter (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (advance),
            .raw     (in_raw_reg[g]),
            .offset  (offset_eff[g]),
            .alpha   (alpha_reg),
            .rate    (rate[g])
        );
    end

    goc_cal_ctrl #(
        .AVG_SHIFT (AVG_SHIFT)
    ) u_cal (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .req        (in_req_reg),
        .cfg        (cal_cfg_reg),
        .rate       (rate),
        .offset_eff (offset_eff),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {rate[2], rate[1], rate[0]};
            out_user_reg <= {status.done, status.phase};
        end
    end

endmodule

// File: rtl/goc_axis_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-axis offset removal and first-order low-pass filter
// Subtracts the axis offset with 16-bit wrap, updates the fixed-point filter
// state and gives the filtered value truncated toward zero.
// ----------------------------------------------------------------------------
module goc_axis_filter
    import goc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  sample_t            raw,
    input  sample_t            offset,
    input  logic [ALPHA_W-1:0] alpha,
    output sample_t            rate
);

    localparam int FW = SAMPLE_W + FRAC_BITS;
    localparam int PW = FW + ALPHA_W + 3;

    logic signed [FW-1:0]        y_reg;
    logic signed [FW-1:0]        y_next;
    sample_t                     x;
    logic signed [ALPHA_W+1:0]   keep;
    logic signed [ALPHA_W:0]     a_s;
    logic signed [PW-1:0]        prod_y;
    logic signed [PW-1:0]        prod_x;
    logic signed [PW-1:0]        num;
    sample_t                     whole;
    logic                        frac_nz;

    always_comb begin
        x       = raw - offset;
        keep    = $signed((18'(1) << ALPHA_W) - {2'b00, alpha});
        a_s     = $signed({1'b0, alpha});
        prod_y  = PW'(y_reg) * PW'(keep);
        prod_x  = (PW'(x) * PW'(a_s)) <<< FRAC_BITS;
        num     = prod_y + prod_x;
        y_next  = FW'(num >>> ALPHA_W);
        whole   = SAMPLE_W'(y_next >>> FRAC_BITS);
        frac_nz = |y_next[FRAC_BITS-1:0];
        rate    = (y_next[FW-1] && frac_nz) ? whole + 16'sd1 : whole;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg <= '0;
        end else if (step) begin
            y_reg <= y_next;
        end
    end

endmodule

// File: rtl/goc_cal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibration sequencer
// Tracks the quiet wait, discard and summing phases, keeps the last outputs,
// the running sums and the axis offsets, and loads new offsets at the end.
// ----------------------------------------------------------------------------
module goc_cal_ctrl
    import goc_pkg::*;
#(
    parameter int AVG_SHIFT = AVG_SHIFT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        req,
    input  cal_cfg_t    cfg,
    input  sample_t     rate       [3],
    output sample_t     offset_eff [3],
    output cal_status_t status
);

    localparam int SW    = SAMPLE_W + AVG_SHIFT;
    localparam int CNT_W = (AVG_SHIFT + 1 > 10) ? AVG_SHIFT + 1 : 10;

    cal_phase_t               phase_reg, phase_next, phase_eff;
    logic [CNT_W-1:0]         cnt_reg, cnt_next, cnt_eff, cnt_inc;
    sample_t                  offset_reg [3];
    sample_t                  offset_next [3];
    sample_t                  prev_reg [3];
    logic signed [SW-1:0]     sum_reg [3];
    logic signed [SW-1:0]     sum_next [3];
    logic signed [SW-1:0]     sum_acc [3];
    logic signed [SAMPLE_W:0] diff;
    logic signed [SAMPLE_W:0] lim;
    logic                     quiet;
    logic                     done;

    always_comb begin
        phase_eff = req ? PH_QUIET : phase_reg;
        cnt_eff   = req ? '0 : cnt_reg;
        cnt_inc   = cnt_eff + CNT_W'(1);
        lim       = $signed({9'b0, cfg.quiet_limit});
        quiet     = 1'b1;
        diff      = '0;
        for (int i = 0; i < 3; i++) begin
            offset_eff[i]  = req ? '0 : offset_reg[i];
            offset_next[i] = offset_eff[i];
            diff = (SAMPLE_W+1)'(rate[i]) - (req ? '0 : (SAMPLE_W+1)'(prev_reg[i]));
            if (diff > lim || diff < -lim) begin
                quiet = 1'b0;
            end
            sum_acc[i]  = (req ? '0 : sum_reg[i]) + SW'(rate[i]);
            sum_next[i] = req ? '0 : sum_reg[i];
        end
        phase_next = phase_eff;
        cnt_next   = cnt_eff;
        done       = 1'b0;
        unique case (phase_eff)
            PH_IDLE: begin
            end
            PH_QUIET: begin
                if (quiet) begin
                    if (cnt_inc >= CNT_W'(cfg.quiet_needed)) begin
                        cnt_next   = '0;
                        phase_next = (cfg.discard_count == '0) ? PH_SUM : PH_DISCARD;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            PH_DISCARD: begin
                if (cnt_inc >= CNT_W'(cfg.discard_count)) begin
                    cnt_next   = '0;
                    phase_next = PH_SUM;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_SUM: begin
                for (int i = 0; i < 3; i++) begin
                    sum_next[i] = sum_acc[i];
                end
                if (cnt_inc >= (CNT_W'(1) << AVG_SHIFT)) begin
                    for (int i = 0; i < 3; i++) begin
                        offset_next[i] = SAMPLE_W'(sum_acc[i] >>> AVG_SHIFT);
                        sum_next[i]    = '0;
                    end
                    cnt_next   = '0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            default: begin
            end
        endcase
        status.phase = phase_next;
        status.done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                offset_reg[i] <= '0;
                prev_reg[i]   <= '0;
                sum_reg[i]    <= '0;
            end
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            for (int i = 0; i < 3; i++) begin
                offset_reg[i] <= offset_next[i];
                prev_reg[i]   <= rate[i];
                sum_reg[i]    <= sum_next[i];
            end
        end
    end

endmodule
